FILE: rtl/core/oci_pkg.sv
// Shared constants, codes and the pipeline item type of the checked integer unit.
package oci_pkg;

   localparam int WIDTH = 32;

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_DIV = 3'd3;
   localparam logic [2:0] CMD_NEG = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_OVF  = 2'd1;
   localparam logic [1:0] ST_UNEG = 2'd2;
   localparam logic [1:0] ST_DIVZ = 2'd3;

   localparam logic [1:0] KIND_PASS = 2'd0;
   localparam logic [1:0] KIND_MUL  = 2'd1;
   localparam logic [1:0] KIND_DIV  = 2'd2;

   localparam logic [WIDTH-1:0] MIN_VAL = {1'b1, {(WIDTH-1){1'b0}}};
   localparam logic [WIDTH-1:0] MAX_POS = {1'b0, {(WIDTH-1){1'b1}}};
   localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};

   // For a multiply, rem holds the high product half and quo the low half.
   // For a pass-through request, quo holds the finished result.
   typedef struct packed {
      logic             valid;
      logic [1:0]       kind;
      logic [1:0]       status;
      logic             sgn;
      logic             neg;
      logic [WIDTH-1:0] rem;
      logic [WIDTH-1:0] quo;
      logic [WIDTH-1:0] divisor;
   } item_type;

endpackage

FILE: rtl/core/oci_front.sv
// Entry stage: decodes the request, finishes simple operations, multiplies, sets up division.
module oci_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     signed_mode,
   input  logic [2:0]               command,
   input  logic [oci_pkg::WIDTH-1:0] lhs,
   input  logic [oci_pkg::WIDTH-1:0] rhs,
   output oci_pkg::item_type        item_out
);
   import oci_pkg::*;

   item_type         item_ff;
   item_type         item_in;
   logic [WIDTH:0]   sum;
   logic [WIDTH:0]   diff;
   logic [WIDTH-1:0] mag_a;
   logic [WIDTH-1:0] mag_b;
   logic [2*WIDTH-1:0] prod;

   assign sum   = {1'b0, lhs} + {1'b0, rhs};
   assign diff  = {1'b0, lhs} - {1'b0, rhs};
   assign mag_a = (signed_mode && lhs[WIDTH-1]) ? (~lhs + 1'b1) : lhs;
   assign mag_b = (signed_mode && rhs[WIDTH-1]) ? (~rhs + 1'b1) : rhs;
   assign prod  = mag_a * mag_b;

   always_comb begin
      item_in         = '0;
      item_in.valid   = accept;
      item_in.kind    = KIND_PASS;
      item_in.status  = ST_OK;
      item_in.sgn     = signed_mode;
      item_in.neg     = signed_mode && (lhs[WIDTH-1] ^ rhs[WIDTH-1]);
      case (command)
         CMD_ADD: begin
            if (signed_mode ? (lhs[WIDTH-1] == rhs[WIDTH-1] &&
                               sum[WIDTH-1] != lhs[WIDTH-1]) : sum[WIDTH])
               item_in.status = ST_OVF;
            else
               item_in.quo = sum[WIDTH-1:0];
         end
         CMD_SUB: begin
            if (signed_mode ? (lhs[WIDTH-1] != rhs[WIDTH-1] &&
                               diff[WIDTH-1] != lhs[WIDTH-1]) : diff[WIDTH])
               item_in.status = ST_OVF;
            else
               item_in.quo = diff[WIDTH-1:0];
         end
         CMD_MUL: begin
            item_in.kind = KIND_MUL;
            item_in.rem  = prod[2*WIDTH-1:WIDTH];
            item_in.quo  = prod[WIDTH-1:0];
         end
         CMD_DIV: begin
            if (rhs == '0)
               item_in.status = ST_DIVZ;
            else if (signed_mode && lhs == MIN_VAL && rhs == ALL_ONES)
               item_in.status = ST_OVF;
            else begin
               item_in.kind    = KIND_DIV;
               item_in.quo     = mag_a;
               item_in.divisor = mag_b;
            end
         end
         CMD_NEG: begin
            if (!signed_mode)
               item_in.status = ST_UNEG;
            else if (lhs == MIN_VAL)
               item_in.status = ST_OVF;
            else
               item_in.quo = ~lhs + 1'b1;
         end
         default: begin
            item_in.quo = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.kind    <= item_in.kind;
      item_ff.status  <= item_in.status;
      item_ff.sgn     <= item_in.sgn;
      item_ff.neg     <= item_in.neg;
      item_ff.rem     <= item_in.rem;
      item_ff.quo     <= item_in.quo;
      item_ff.divisor <= item_in.divisor;
   end

   assign item_out = item_ff;

endmodule

FILE: rtl/core/oci_cell.sv
// One restoring division step; every request passes through each cell's register.
module oci_cell (
   input  logic              clock,
   input  logic              reset,
   input  oci_pkg::item_type item_in_port,
   output oci_pkg::item_type item_out
);
   import oci_pkg::*;

   item_type         item_ff;
   item_type         item_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH+1:0] trial;

   assign shifted = {item_in_port.rem, item_in_port.quo[WIDTH-1]};
   assign trial   = {1'b0, shifted} - {2'b00, item_in_port.divisor};

   always_comb begin
      item_in = item_in_port;
      if (item_in_port.kind == KIND_DIV) begin
         if (!trial[WIDTH+1]) begin
            item_in.rem = trial[WIDTH-1:0];
            item_in.quo = {item_in_port.quo[WIDTH-2:0], 1'b1};
         end else begin
            item_in.rem = shifted[WIDTH-1:0];
            item_in.quo = {item_in_port.quo[WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.kind    <= item_in.kind;
      item_ff.status  <= item_in.status;
      item_ff.sgn     <= item_in.sgn;
      item_ff.neg     <= item_in.neg;
      item_ff.rem     <= item_in.rem;
      item_ff.quo     <= item_in.quo;
      item_ff.divisor <= item_in.divisor;
   end

   assign item_out = item_ff;

endmodule

FILE: rtl/core/oci_back.sv
// Exit stage: multiply range check, quotient sign fix and the output register.
module oci_back (
   input  logic                      clock,
   input  logic                      reset,
   input  oci_pkg::item_type         item_in_port,
   output logic                      valid,
   output logic [oci_pkg::WIDTH-1:0] result,
   output logic [1:0]                status
);
   import oci_pkg::*;

   logic             valid_ff;
   logic [WIDTH-1:0] result_ff;
   logic [WIDTH-1:0] result_in;
   logic [1:0]       status_ff;
   logic [1:0]       status_in;
   logic             mul_neg;
   logic [WIDTH-1:0] limit;

   always_comb begin
      mul_neg   = item_in_port.neg && (item_in_port.rem != '0 || item_in_port.quo != '0);
      limit     = mul_neg ? MIN_VAL : (item_in_port.sgn ? MAX_POS : ALL_ONES);
      result_in = item_in_port.quo;
      status_in = item_in_port.status;
      unique case (item_in_port.kind)
         KIND_MUL: begin
            if (item_in_port.rem != '0 || item_in_port.quo > limit) begin
               status_in = ST_OVF;
               result_in = '0;
            end else if (mul_neg) begin
               result_in = ~item_in_port.quo + 1'b1;
            end
         end
         KIND_DIV: begin
            if (item_in_port.neg)
               result_in = ~item_in_port.quo + 1'b1;
         end
         default: begin
            result_in = item_in_port.quo;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= item_in_port.valid;
      end
      result_ff <= result_in;
      status_ff <= status_in;
   end

   assign valid  = valid_ff;
   assign result = result_ff;
   assign status = status_ff;

endmodule

FILE: rtl/core/overflow_checked_integer_alu_unit.sv
// Top level of the overflow-checked integer unit: mode register, entry stage, cell row, exit stage.
// Usage:
// A request is taken at each rising edge with start high and busy low. busy is
// always low, so a new request may enter every cycle (one request per cycle).
// Each request yields one response: rsp_valid is high for one cycle with
// rsp_result and rsp_status. Every command passes through one entry stage,
// one cell per quotient bit in the division row, and one exit stage.
// Every request travels the whole row, so responses
// leave in request order. The receiver cannot stall; responses must be taken
// in the cycle they appear.
// csr_write_enable with csr_write_data sets the signed mode; it is sampled
// when a request is taken. Write it only while no request is in flight.
// Reset empties the pipeline (no responses in flight) and sets signed mode.
module overflow_checked_integer_alu_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_command,
   input  logic [31:0]               req_lhs,
   input  logic [31:0]               req_rhs,
   output logic                      rsp_valid,
   output logic [31:0]               rsp_result,
   output logic [1:0]                rsp_status,
   input  logic                      csr_write_enable,
   input  logic                      csr_write_data
);
   import oci_pkg::*;

   logic     signed_mode_ff;
   logic     signed_mode_in;
   item_type chain [WIDTH+1];

   assign busy = 1'b0;

   always_comb begin
      signed_mode_in = csr_write_enable ? csr_write_data : signed_mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b1;
      end else begin
         signed_mode_ff <= signed_mode_in;
      end
   end

   oci_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (start && !busy),
      .signed_mode (signed_mode_ff),
      .command     (req_command),
      .lhs         (req_lhs),
      .rhs         (req_rhs),
      .item_out    (chain[0])
   );

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      oci_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .item_in_port (chain[i]),
         .item_out     (chain[i+1])
      );
   end

   oci_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item_in_port (chain[WIDTH]),
      .valid        (rsp_valid),
      .result       (rsp_result),
      .status       (rsp_status)
   );

endmodule
